/* rtl/akt_pkg.sv */
package akt_pkg;

    localparam int KEY_FIELD_W = 64;
    localparam int TIME_W      = 32;
    localparam int SLOT_W      = 2;
    localparam int MASK_W      = 4;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5;
    localparam logic              REG_TIMEOUT   = 1'b0;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic key_eq;
        logic stamp_lt;
        logic expired;
    } t_eval;

endpackage

/* rtl/akt_ram.sv */
module akt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/akt_cmp.sv */
module akt_cmp #(
    parameter int KEY_BITS = 64
) (
    input  logic [KEY_BITS-1:0]            i_key_a,
    input  logic [KEY_BITS-1:0]            i_key_b,
    input  logic [akt_pkg::TIME_W-1:0]     i_stamp,
    input  logic [akt_pkg::TIME_W-1:0]     i_old_stamp,
    input  logic [akt_pkg::TIME_W-1:0]     i_now,
    input  logic [akt_pkg::TIME_W-1:0]     i_timeout,
    output akt_pkg::t_eval                 o_eval
);

    logic [akt_pkg::TIME_W-1:0] w_age;

    // age saturates at zero when time runs backward
    assign w_age = (i_now >= i_stamp) ? (i_now - i_stamp) : '0;

    always_comb begin
        o_eval.key_eq   = (i_key_a == i_key_b);
        o_eval.stamp_lt = (i_stamp < i_old_stamp);
        o_eval.expired  = (w_age > i_timeout);
    end

endmodule

/* rtl/aging_key_table.sv */
// An accepted request runs through S_SCAN, S_LAST (compare of the last entry read) and
// S_WRITE, and no new request is taken until the sequencer is back in S_IDLE. The single
// table read port visits one entry per cycle in S_SCAN; S_WRITE holds on output stall.
// A finished result waits in the output register while the next request is taken.
// Reset (i_rst_n low, synchronous): valid marks cleared, timeout set to 5;
// key and stamp storage is not cleared.
module aging_key_table #(
    parameter int ENTRIES  = 4,
    parameter int KEY_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_opcode,
    input  logic [akt_pkg::KEY_FIELD_W-1:0]     i_key,
    input  logic [akt_pkg::TIME_W-1:0]          i_now_time,

    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_status,
    output logic [akt_pkg::SLOT_W-1:0]          o_slot,
    output logic                                o_did_evict,
    output logic [akt_pkg::KEY_FIELD_W-1:0]     o_evicted_key,
    output logic [akt_pkg::MASK_W-1:0]          o_expired_mask,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [akt_pkg::ADDR_W-1:0]          paddr,
    input  logic [akt_pkg::DATA_W-1:0]          pwdata,
    output logic [akt_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = KEY_BITS + akt_pkg::TIME_W;

    akt_pkg::t_state r_state, n_state;

    logic [akt_pkg::TIME_W-1:0]      r_timeout;
    logic [ENTRIES-1:0]              r_valid;

    akt_pkg::t_op                    r_op;
    logic [KEY_BITS-1:0]             r_key;
    logic [akt_pkg::TIME_W-1:0]      r_now;

    logic [IW-1:0]                   r_idx;
    logic                            r_cv;
    logic [IW-1:0]                   r_ci;

    logic                            r_found;
    logic                            r_hit_free;
    logic [IW-1:0]                   r_hit;
    logic [IW-1:0]                   r_old_idx;
    logic [akt_pkg::TIME_W-1:0]      r_old_stamp;
    logic [KEY_BITS-1:0]             r_old_key;
    logic [akt_pkg::MASK_W-1:0]      r_mask;

    logic                            r_out_vld;
    logic                            r_out_status;
    logic [akt_pkg::SLOT_W-1:0]      r_out_slot;
    logic                            r_out_evict;
    logic [akt_pkg::KEY_FIELD_W-1:0] r_out_evk;
    logic [akt_pkg::MASK_W-1:0]      r_out_mask;

    logic                            w_in_acc;
    logic                            w_fire;
    logic                            w_cfg_wr;
    logic                            w_is_add;
    logic                            w_is_lookup;
    logic                            w_ram_we;
    logic [IW-1:0]                   w_waddr;
    logic [IW-1:0]                   w_slot_idx;
    logic [IW+1:0]                   w_slot_ext;
    logic [IW+2:0]                   w_ci_ext;
    logic [RW-1:0]                   w_rdata;
    logic [KEY_BITS-1:0]             w_rd_key;
    logic [akt_pkg::TIME_W-1:0]      w_rd_stamp;
    logic                            w_rd_valid;
    logic                            w_match;
    akt_pkg::t_eval                  w_eval;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == akt_pkg::REG_TIMEOUT);
    assign prdata   = (paddr[2] == akt_pkg::REG_TIMEOUT) ? r_timeout : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= akt_pkg::TIMEOUT_RESET;
        end else if (w_cfg_wr) begin
            r_timeout <= pwdata;
        end
    end

    // table storage: {key, stamp}
    akt_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_key, r_now}),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_key   = w_rdata[RW-1:akt_pkg::TIME_W];
    assign w_rd_stamp = w_rdata[akt_pkg::TIME_W-1:0];
    assign w_rd_valid = r_valid[r_ci];

    akt_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .i_key_a     (w_rd_key),
        .i_key_b     (r_key),
        .i_stamp     (w_rd_stamp),
        .i_old_stamp (r_old_stamp),
        .i_now       (r_now),
        .i_timeout   (r_timeout),
        .o_eval      (w_eval)
    );

    assign w_match     = w_rd_valid && w_eval.key_eq;
    assign w_is_add    = (r_op == akt_pkg::OP_ADD);
    assign w_is_lookup = (r_op == akt_pkg::OP_REMOVE) || (r_op == akt_pkg::OP_SEARCH);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_waddr     = r_found ? r_hit : r_old_idx;
    assign w_ram_we    = w_fire && w_is_add && (!r_found || r_hit_free);
    assign w_ci_ext    = {3'b000, r_ci};

    always_comb begin
        if (w_is_add) begin
            w_slot_idx = w_waddr;
        end else if (w_is_lookup && r_found) begin
            w_slot_idx = r_hit;
        end else begin
            w_slot_idx = '0;
        end
    end
    assign w_slot_ext = {2'b00, w_slot_idx};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= akt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        w_fire  = 1'b0;
        case (r_state)
            akt_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = akt_pkg::S_SCAN;
                end
            end
            akt_pkg::S_SCAN: begin
                if (r_idx == IW'(ENTRIES - 1)) begin
                    n_state = akt_pkg::S_LAST;
                end
            end
            akt_pkg::S_LAST: begin
                n_state = akt_pkg::S_WRITE;
            end
            akt_pkg::S_WRITE: begin
                w_fire = !r_out_vld || !i_stall;
                if (w_fire) begin
                    n_state = akt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = akt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_cv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cv <= (r_state == akt_pkg::S_SCAN);
            if (r_state == akt_pkg::S_SCAN) begin
                r_ci <= r_idx;
            end

            if (w_in_acc) begin
                r_op    <= akt_pkg::t_op'(i_opcode);
                r_key   <= i_key[KEY_BITS-1:0];
                r_now   <= i_now_time;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_mask  <= '0;
            end else if (r_state == akt_pkg::S_SCAN) begin
                r_idx <= r_idx + 1'b1;
            end

            if (r_cv) begin
                if (w_is_add && !r_found && (!w_rd_valid || w_match)) begin
                    r_found    <= 1'b1;
                    r_hit      <= r_ci;
                    r_hit_free <= !w_rd_valid;
                end
                if (w_is_lookup && !r_found && w_match) begin
                    r_found <= 1'b1;
                    r_hit   <= r_ci;
                end
                if ((r_ci == '0) || w_eval.stamp_lt) begin
                    r_old_idx   <= r_ci;
                    r_old_stamp <= w_rd_stamp;
                    r_old_key   <= w_rd_key;
                end
                if ((r_op == akt_pkg::OP_TICK) && w_rd_valid && w_eval.expired) begin
                    r_valid[r_ci] <= 1'b0;
                    if (w_ci_ext < (IW + 3)'(akt_pkg::MASK_W)) begin
                        r_mask[w_ci_ext[1:0]] <= 1'b1;
                    end
                end
            end

            if (w_fire) begin
                if (w_ram_we) begin
                    r_valid[w_waddr] <= 1'b1;
                end
                if ((r_op == akt_pkg::OP_REMOVE) && r_found) begin
                    r_valid[r_hit] <= 1'b0;
                end
                r_out_vld    <= 1'b1;
                r_out_status <= w_is_lookup && !r_found;
                r_out_slot   <= w_slot_ext[akt_pkg::SLOT_W-1:0];
                r_out_evict  <= w_is_add && !r_found;
                r_out_evk    <= (w_is_add && !r_found) ?
                                akt_pkg::KEY_FIELD_W'(r_old_key) : '0;
                r_out_mask   <= (r_op == akt_pkg::OP_TICK) ? r_mask : '0;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_did_evict    = r_out_evict;
    assign o_evicted_key  = r_out_evk;
    assign o_expired_mask = r_out_mask;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == akt_pkg::S_SCAN))
        else $error("accepted request did not start a scan");

    a_evict_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == akt_pkg::S_WRITE) && w_is_add && !r_found |-> (&r_valid))
        else $error("replacement chosen while a free entry exists");

    a_add_leaves_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_is_add |=> (r_valid != '0))
        else $error("add left the table empty");

    a_evict_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_did_evict |-> !o_status && (o_expired_mask == '0))
        else $error("eviction result carries lookup or tick fields");

    a_no_scan_while_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> (r_state == akt_pkg::S_SCAN) || (r_state == akt_pkg::S_LAST))
        else $error("compare slot active outside scan");

endmodule

/* tb/sv/tb_aging_key_table.sv */
`timescale 1ns / 100ps

module tb_aging_key_table;

    localparam int NUM_ENTRIES = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam logic [akt_pkg::ADDR_W-1:0] TIMEOUT_ADDR =
        akt_pkg::ADDR_W'(4 * akt_pkg::REG_TIMEOUT);
    localparam logic [akt_pkg::ADDR_W-1:0] SPARE_ADDR   = akt_pkg::ADDR_W'(4);

    typedef struct packed {
        akt_pkg::t_op                    op;
        logic [akt_pkg::KEY_FIELD_W-1:0] key;
        logic [akt_pkg::TIME_W-1:0]      now;
    } t_table_req;

    typedef struct packed {
        logic                            status;
        logic [akt_pkg::SLOT_W-1:0]      slot;
        logic                            evict;
        logic [akt_pkg::KEY_FIELD_W-1:0] ekey;
        logic [akt_pkg::MASK_W-1:0]      mask;
    } t_table_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [1:0]                      i_opcode = '0;
    logic [akt_pkg::KEY_FIELD_W-1:0] i_key = '0;
    logic [akt_pkg::TIME_W-1:0]      i_now_time = '0;

    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic                            o_status;
    logic [akt_pkg::SLOT_W-1:0]      o_slot;
    logic                            o_did_evict;
    logic [akt_pkg::KEY_FIELD_W-1:0] o_evicted_key;
    logic [akt_pkg::MASK_W-1:0]      o_expired_mask;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [akt_pkg::ADDR_W-1:0]      paddr = '0;
    logic [akt_pkg::DATA_W-1:0]      pwdata = '0;
    logic [akt_pkg::DATA_W-1:0]      prdata;
    logic                            pready;

    // table model
    logic                            tbl_valid [NUM_ENTRIES];
    logic [akt_pkg::KEY_FIELD_W-1:0] tbl_key   [NUM_ENTRIES];
    logic [akt_pkg::TIME_W-1:0]      tbl_stamp [NUM_ENTRIES];
    logic [akt_pkg::TIME_W-1:0]      cur_timeout;

    t_table_req   request_q [$];
    t_table_reply reply_q [$];
    t_table_req   next_req;
    t_table_reply got_reply;
    t_table_reply want_reply;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  mismatches = 0;
    int  hold_left = 0;
    int  cycle_cnt = 0;
    bit  hold_arm = 1'b0;
    bit  hold_taken = 1'b0;

    aging_key_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_key          (i_key),
        .i_now_time     (i_now_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_did_evict    (o_did_evict),
        .o_evicted_key  (o_evicted_key),
        .o_expired_mask (o_expired_mask),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_table_reply table_apply(akt_pkg::t_op op,
                                                 logic [akt_pkg::KEY_FIELD_W-1:0] key,
                                                 logic [akt_pkg::TIME_W-1:0] now);
        t_table_reply r;
        int hit;
        int oldest;
        logic [akt_pkg::TIME_W-1:0] age;
        r = '0;
        hit = -1;
        case (op)
            akt_pkg::OP_ADD: begin
                for (int i = 0; i < NUM_ENTRIES && hit < 0; i++) begin
                    if (!tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1;
                        tbl_key[i] = key;
                        tbl_stamp[i] = now;
                        hit = i;
                    end else if (tbl_key[i] == key) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    oldest = 0;
                    for (int i = 1; i < NUM_ENTRIES; i++)
                        if (tbl_stamp[i] < tbl_stamp[oldest])
                            oldest = i;
                    r.evict = 1'b1;
                    r.ekey = tbl_key[oldest];
                    tbl_key[oldest] = key;
                    tbl_stamp[oldest] = now;
                    hit = oldest;
                end
                r.slot = akt_pkg::SLOT_W'(hit);
            end
            akt_pkg::OP_REMOVE, akt_pkg::OP_SEARCH: begin
                for (int i = 0; i < NUM_ENTRIES && hit < 0; i++)
                    if (tbl_valid[i] && tbl_key[i] == key)
                        hit = i;
                if (hit < 0) begin
                    r.status = 1'b1;
                end else begin
                    r.slot = akt_pkg::SLOT_W'(hit);
                    if (op == akt_pkg::OP_REMOVE)
                        tbl_valid[hit] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        age = (now >= tbl_stamp[i]) ? now - tbl_stamp[i] : '0;
                        if (age > cur_timeout) begin
                            tbl_valid[i] = 1'b0;
                            r.mask[i] = 1'b1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                reply_q.push_back(table_apply(akt_pkg::t_op'(i_opcode), i_key, i_now_time));
            if (!i_valid || !o_stall) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = request_q.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= next_req.op;
                    i_key <= next_req.key;
                    i_now_time <= next_req.now;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_reply = '{o_status, o_slot, o_did_evict, o_evicted_key, o_expired_mask};
            if (reply_q.size() == 0) begin
                $error("result transaction with no request outstanding");
                mismatches++;
            end else begin
                want_reply = reply_q.pop_front();
                if (got_reply.status !== want_reply.status) begin
                    $error("status: expected %0h, got %0h", want_reply.status, got_reply.status);
                    mismatches++;
                end
                if (got_reply.slot !== want_reply.slot) begin
                    $error("slot: expected %0h, got %0h", want_reply.slot, got_reply.slot);
                    mismatches++;
                end
                if (got_reply.evict !== want_reply.evict) begin
                    $error("did_evict: expected %0h, got %0h", want_reply.evict, got_reply.evict);
                    mismatches++;
                end
                if (got_reply.ekey !== want_reply.ekey) begin
                    $error("evicted_key: expected %0h, got %0h", want_reply.ekey, got_reply.ekey);
                    mismatches++;
                end
                if (got_reply.mask !== want_reply.mask) begin
                    $error("expired_mask: expected %0h, got %0h", want_reply.mask, got_reply.mask);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("aging_key_table: mismatch");
            $finish;
        end
    end

    task automatic push_req(akt_pkg::t_op op, logic [akt_pkg::KEY_FIELD_W-1:0] key,
                            logic [akt_pkg::TIME_W-1:0] now);
        request_q.push_back('{op, key, now});
    endtask

    task automatic reg_write(logic [akt_pkg::ADDR_W-1:0] addr,
                             logic [akt_pkg::DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == TIMEOUT_ADDR)
            cur_timeout = data;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_valid || reply_q.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic random_requests(int count);
        logic [akt_pkg::KEY_FIELD_W-1:0] pool [6];
        logic [akt_pkg::TIME_W-1:0] clock_s;
        logic [akt_pkg::KEY_FIELD_W-1:0] key;
        logic [akt_pkg::TIME_W-1:0] now;
        int pick;
        akt_pkg::t_op op;
        foreach (pool[i])
            pool[i] = {$urandom, $urandom};
        clock_s = $urandom;
        for (int n = 0; n < count; n++) begin
            clock_s += $urandom_range(3);
            pick = $urandom_range(99);
            if (pick < 40)
                op = akt_pkg::OP_ADD;
            else if (pick < 55)
                op = akt_pkg::OP_REMOVE;
            else if (pick < 80)
                op = akt_pkg::OP_SEARCH;
            else
                op = akt_pkg::OP_TICK;
            key = ($urandom_range(99) < 5) ? {$urandom, $urandom} : pool[$urandom_range(5)];
            now = ($urandom_range(99) < 5) ? akt_pkg::TIME_W'($urandom) : clock_s;
            push_req(op, key, now);
        end
    endtask

    initial begin
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_stamp[i] = '0;
        end
        cur_timeout = akt_pkg::TIMEOUT_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write to an unmapped register must leave the timeout alone
        reg_write(SPARE_ADDR, 32'd0);
        send_idle_pct = 31;
        recv_idle_pct = 73;
        push_req(akt_pkg::OP_SEARCH, 64'd0, 32'd0);
        push_req(akt_pkg::OP_REMOVE, 64'd0, 32'd0);
        push_req(akt_pkg::OP_TICK, 64'd0, 32'd0);
        push_req(akt_pkg::OP_ADD, 64'd0, 32'd10);
        push_req(akt_pkg::OP_ADD, '1, 32'd11);
        push_req(akt_pkg::OP_ADD, 64'd0, 32'd50);
        push_req(akt_pkg::OP_ADD, 64'h0123_4567_89ab_cdef, 32'd10);
        push_req(akt_pkg::OP_ADD, 64'hfedc_ba98_7654_3210, 32'd12);
        push_req(akt_pkg::OP_ADD, 64'h8000_0000_0000_0001, 32'd20);
        push_req(akt_pkg::OP_SEARCH, '1, 32'd0);
        push_req(akt_pkg::OP_SEARCH, 64'd0, 32'd0);
        push_req(akt_pkg::OP_REMOVE, 64'h0123_4567_89ab_cdef, 32'd0);
        push_req(akt_pkg::OP_ADD, 64'd0, 32'd13);
        push_req(akt_pkg::OP_REMOVE, 64'h8000_0000_0000_0001, 32'd0);
        push_req(akt_pkg::OP_ADD, 64'd0, 32'd14);
        push_req(akt_pkg::OP_SEARCH, 64'd0, 32'd0);
        push_req(akt_pkg::OP_TICK, 64'd0, 32'd16);
        push_req(akt_pkg::OP_TICK, 64'd0, 32'd17);
        push_req(akt_pkg::OP_TICK, '1, '1);
        push_req(akt_pkg::OP_ADD, 64'h5555_5555_5555_5555, '1);
        push_req(akt_pkg::OP_ADD, 64'haaaa_aaaa_aaaa_aaaa, 32'd0);
        push_req(akt_pkg::OP_SEARCH, 64'h5555_5555_5555_5555, 32'd0);
        push_req(akt_pkg::OP_TICK, 64'd0, 32'd0);
        push_req(akt_pkg::OP_REMOVE, 64'haaaa_aaaa_aaaa_aaaa, 32'd0);
        push_req(akt_pkg::OP_REMOVE, 64'h5555_5555_5555_5555, 32'd0);
        random_requests(400);
        drain();

        reg_write(TIMEOUT_ADDR, 32'd0);
        send_idle_pct = 73;
        recv_idle_pct = 31;
        random_requests(400);
        drain();

        reg_write(TIMEOUT_ADDR, '1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_requests(400);
        drain();

        reg_write(TIMEOUT_ADDR, akt_pkg::DATA_W'($urandom_range(2, 12)));
        hold_arm = 1'b1;
        random_requests(400);
        drain();

        if (mismatches == 0 && reply_q.size() == 0)
            $display("aging_key_table: match");
        else
            $display("aging_key_table: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/akt_pkg.sv
rtl/akt_ram.sv
rtl/akt_cmp.sv
rtl/aging_key_table.sv
tb/sv/tb_aging_key_table.sv
